>>> design/ssat_pkg.sv
// Shared constants, types and the sine table generator for the stereo sine saturator.
package ssat_pkg;

	localparam int DEF_SAMPLE_BITS     = 24;
	localparam int DEF_SINE_TABLE_BITS = 10;

	// configuration port
	localparam int CFG_W   = 19;
	localparam int IDX_W   = 3;
	localparam int GAIN_W  = 19;
	localparam int COEF_W  = 17;
	localparam logic [IDX_W-1:0] REG_INPUT_GAIN     = 3'd0;
	localparam logic [IDX_W-1:0] REG_HIGHPASS_COEFF = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRESENCE_MIX   = 3'd2;
	localparam logic [IDX_W-1:0] REG_OUTPUT_LEVEL   = 3'd3;
	localparam logic [IDX_W-1:0] REG_WET_MIX        = 3'd4;
	localparam logic [COEF_W-1:0] UNITY             = 17'h10000;
	localparam logic [GAIN_W-1:0] GAIN_RESET        = 19'h10000;

	// datapath widths (Q.32 working format)
	localparam int DRY_W  = 33;
	localparam int X_W    = 37;
	localparam int LP_W   = 40;
	localparam int H_W    = 38;
	localparam int MAG_W  = 37;
	localparam int SH_W   = 46;
	localparam int MB_W   = 20;
	localparam int MP_W   = SH_W + MB_W;
	localparam int SP_W   = 58;
	localparam int SMALL_BIT = 38;
	localparam int SINE_W = 31;
	localparam logic [29:0] INV_TWO_PI = 30'd683565276;

	// divider
	localparam int DIV_Q_BITS     = 44;
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_STEPS      = DIV_Q_BITS / DIV_RADIX_BITS;
	localparam int STEP_W         = $clog2(DIV_STEPS);
	localparam int REM_W          = MAG_W + 1;

	// operation codes, also the controller states
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_IDLE      = 5'd0;
	localparam logic [OP_W-1:0] OP_GAIN_X    = 5'd1;
	localparam logic [OP_W-1:0] OP_GAIN_P    = 5'd2;
	localparam logic [OP_W-1:0] OP_LP1       = 5'd3;
	localparam logic [OP_W-1:0] OP_LP2       = 5'd4;
	localparam logic [OP_W-1:0] OP_LP_SUM    = 5'd5;
	localparam logic [OP_W-1:0] OP_HP        = 5'd6;
	localparam logic [OP_W-1:0] OP_SH_PROD   = 5'd7;
	localparam logic [OP_W-1:0] OP_SH_T1     = 5'd8;
	localparam logic [OP_W-1:0] OP_SH_T2     = 5'd9;
	localparam logic [OP_W-1:0] OP_SH_PHASE  = 5'd10;
	localparam logic [OP_W-1:0] OP_SH_ROM    = 5'd11;
	localparam logic [OP_W-1:0] OP_SH_INTERP = 5'd12;
	localparam logic [OP_W-1:0] OP_DIV_INIT  = 5'd13;
	localparam logic [OP_W-1:0] OP_DIV_STEP  = 5'd14;
	localparam logic [OP_W-1:0] OP_SH_DONE   = 5'd15;
	localparam logic [OP_W-1:0] OP_OL_M      = 5'd16;
	localparam logic [OP_W-1:0] OP_OL_Q      = 5'd17;
	localparam logic [OP_W-1:0] OP_PM1       = 5'd18;
	localparam logic [OP_W-1:0] OP_PM2       = 5'd19;
	localparam logic [OP_W-1:0] OP_PM3       = 5'd20;
	localparam logic [OP_W-1:0] OP_WM1       = 5'd21;
	localparam logic [OP_W-1:0] OP_WM2       = 5'd22;
	localparam logic [OP_W-1:0] OP_WM3       = 5'd23;
	localparam logic [OP_W-1:0] OP_OUT       = 5'd24;
	localparam logic [OP_W-1:0] OP_EMIT      = 5'd25;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [COEF_W-1:0] hp_coeff;
		logic [COEF_W-1:0] pres_mix;
		logic [COEF_W-1:0] out_level;
		logic [COEF_W-1:0] wet_mix;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ch;
		logic            pres;
		logic            capture;
	} cmd_t;

	// quarter-wave sine entry, Q.30, odd Taylor polynomial with floor shifts
	function automatic longint sine_entry(input int tb, input int i);
		longint x;
		longint u;
		longint acc;
		x = longint'(i) <<< (30 - tb);
		u = (x * x) >>> 30;
		acc = -longint'(3864);
		acc = longint'(172272) + ((acc * u) >>> 30);
		acc = -longint'(5026995) + ((acc * u) >>> 30);
		acc = longint'(85569306) + ((acc * u) >>> 30);
		acc = -longint'(693598668) + ((acc * u) >>> 30);
		acc = longint'(1686629713) + ((acc * u) >>> 30);
		acc = (acc * x) >>> 30;
		if (acc < 0) acc = 0;
		if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
		return acc;
	endfunction

endpackage

>>> design/ssat_in_if.sv
// Input frame channel: valid/ready plus one stereo frame.
interface ssat_in_if import ssat_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, left_sample, right_sample, input ready);
	modport sink (input valid, left_sample, right_sample, output ready);
endinterface

>>> design/ssat_out_if.sv
// Output frame channel: valid/ready plus one processed stereo frame.
interface ssat_out_if import ssat_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

>>> design/ssat_ctrl.sv
// Sequencer: steps the datapath through both channels of a frame and runs the handshakes.
module ssat_ctrl import ssat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	logic [OP_W-1:0]   state_q, state_d;
	logic              ch_q, ch_d;
	logic              pres_q, pres_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              out_valid_q;
	logic              can_emit;

	assign can_emit  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == OP_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		pres_d  = pres_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			OP_IDLE: begin
				ch_d   = 1'b0;
				pres_d = 1'b0;
				if (in_valid) state_d = OP_GAIN_X;
			end
			OP_GAIN_X:    state_d = OP_GAIN_P;
			OP_GAIN_P:    state_d = OP_LP1;
			OP_LP1:       state_d = OP_LP2;
			OP_LP2:       state_d = OP_LP_SUM;
			OP_LP_SUM:    state_d = OP_HP;
			OP_HP:        state_d = OP_SH_PROD;
			OP_SH_PROD:   state_d = OP_SH_T1;
			OP_SH_T1:     state_d = OP_SH_T2;
			OP_SH_T2:     state_d = OP_SH_PHASE;
			OP_SH_PHASE:  state_d = OP_SH_ROM;
			OP_SH_ROM:    state_d = OP_SH_INTERP;
			OP_SH_INTERP: state_d = OP_DIV_INIT;
			OP_DIV_INIT: begin
				cnt_d   = '0;
				state_d = OP_DIV_STEP;
			end
			OP_DIV_STEP: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = OP_SH_DONE;
			end
			OP_SH_DONE: begin
				// main path first, then the presence path
				if (!pres_q) begin
					pres_d  = 1'b1;
					state_d = OP_SH_PROD;
				end else begin
					state_d = OP_OL_M;
				end
			end
			OP_OL_M: state_d = OP_OL_Q;
			OP_OL_Q: state_d = OP_PM1;
			OP_PM1:  state_d = OP_PM2;
			OP_PM2:  state_d = OP_PM3;
			OP_PM3:  state_d = OP_WM1;
			OP_WM1:  state_d = OP_WM2;
			OP_WM2:  state_d = OP_WM3;
			OP_WM3:  state_d = OP_OUT;
			OP_OUT: begin
				if (!ch_q) begin
					ch_d    = 1'b1;
					pres_d  = 1'b0;
					state_d = OP_GAIN_X;
				end else begin
					state_d = OP_EMIT;
				end
			end
			OP_EMIT: if (can_emit) state_d = OP_IDLE;
			default: state_d = OP_IDLE;
		endcase
	end

	always_comb begin
		cmd.op      = state_q;
		cmd.ch      = ch_q;
		cmd.pres    = pres_q;
		cmd.capture = in_valid && (state_q == OP_IDLE);
		// hold the frame until the output register frees up
		if (state_q == OP_EMIT && !can_emit) cmd.op = OP_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= OP_IDLE;
			ch_q        <= 1'b0;
			pres_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			pres_q  <= pres_d;
			cnt_q   <= cnt_d;
			if (state_q == OP_EMIT && can_emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> design/ssat_dp.sv
// Datapath: gain, alternating one-pole highpass, sine shaper with divider, level and mixes.
module ssat_dp import ssat_pkg::*; #(
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
	parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  cfg_t                          cfg,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out
);

	localparam int DRY_SHIFT = DRY_W - SAMPLE_BITS;
	localparam int FR_W      = 30 - SINE_TABLE_BITS;
	localparam int TAB_N     = (1 << SINE_TABLE_BITS) + 1;
	localparam int TI_W      = SINE_TABLE_BITS + 1;
	localparam int IP_W      = 33 + FR_W;
	localparam logic signed [SH_W-1:0] SAT_HI =
		SH_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
	localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

	typedef logic [SINE_W-1:0] rom_t [TAB_N];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < TAB_N; i++) r[i] = SINE_W'(sine_entry(SINE_TABLE_BITS, i));
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// frame and filter state
	logic signed [SAMPLE_BITS-1:0] smp_q  [2];
	logic signed [SAMPLE_BITS-1:0] prev_q [2];
	logic signed [SAMPLE_BITS-1:0] stage_q [2];
	logic signed [LP_W-1:0]        lp_a_q [2];
	logic signed [LP_W-1:0]        lp_b_q [2];
	logic                          fsel_q;

	// working registers
	logic signed [X_W-1:0]  x_q, p_q;
	logic signed [MP_W-1:0] acc1_q, acc2_q;
	logic signed [H_W-1:0]  h_q;
	logic [SP_W-1:0]        sp_q;
	logic [55:0]            t1_q;
	logic [29:0]            t2_q;
	logic [31:0]            phase_q;
	logic [SINE_W-1:0]      v0_q, v1_q, sm_q;
	logic                   sneg_q;
	logic [REM_W-1:0]       rem_q;
	logic [DIV_Q_BITS-1:0]  num_q, quo_q;
	logic                   sat_q;
	logic signed [SH_W-1:0] m_q, q_q, y_q;

	// combinational
	logic signed [SAMPLE_BITS-1:0] smp_sel, prev_sel;
	logic signed [DRY_W-1:0]       dry, prev_dry;
	logic signed [LP_W-1:0]        lp_sel, lp_new;
	logic signed [SH_W-1:0]        mul_a;
	logic signed [MB_W-1:0]        mul_b;
	logic signed [MP_W-1:0]        mprod;
	logic signed [MP_W:0]          acc_sum;
	logic signed [MP_W:0]          acc_shift;
	logic [COEF_W-1:0]             one_minus_c, one_minus_pm, one_minus_wm;
	logic [MAG_W-1:0]              hm, pmag, dv;
	logic                          hneg;
	logic [33:0]                   smul_a;
	logic [29:0]                   smul_b;
	logic [63:0]                   sprod;
	logic [55:0]                   ph_sum;
	logic [30:0]                   pos;
	logic [TI_W-1:0]               tidx, tidx1;
	logic [FR_W-1:0]               fr;
	logic signed [31:0]            sdiff;
	logic signed [IP_W-1:0]        ip;
	logic signed [31:0]            interp;
	logic [REM_W-1:0]              rem_init;
	logic [REM_W-1:0]              div_r;
	logic [DIV_Q_BITS-1:0]         div_n, div_qv;
	logic [DIV_Q_BITS:0]           mag;
	logic                          small_arg, dzero, sh_neg;
	logic signed [SH_W-1:0]        sh_sel, sh_res;
	logic signed [SH_W-1:0]        y_sh;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	assign smp_sel  = smp_q[cmd.ch];
	assign prev_sel = prev_q[cmd.ch];
	assign dry      = {smp_sel, {DRY_SHIFT{1'b0}}};
	assign prev_dry = {prev_sel, {DRY_SHIFT{1'b0}}};
	assign lp_sel   = fsel_q ? lp_a_q[cmd.ch] : lp_b_q[cmd.ch];

	assign one_minus_c  = UNITY - cfg.hp_coeff;
	assign one_minus_pm = UNITY - cfg.pres_mix;
	assign one_minus_wm = UNITY - cfg.wet_mix;

	// shared signed multiplier for gain, filter, level and mixes
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_GAIN_X: begin
				mul_a = SH_W'(dry);
				mul_b = signed'({1'b0, cfg.gain});
			end
			OP_GAIN_P: begin
				mul_a = SH_W'(prev_dry);
				mul_b = signed'({1'b0, cfg.gain});
			end
			OP_LP1: begin
				mul_a = SH_W'(lp_sel);
				mul_b = signed'({3'b000, one_minus_c});
			end
			OP_LP2: begin
				mul_a = SH_W'(x_q);
				mul_b = signed'({3'b000, cfg.hp_coeff});
			end
			OP_OL_M: begin
				mul_a = m_q;
				mul_b = signed'({3'b000, cfg.out_level});
			end
			OP_OL_Q: begin
				mul_a = q_q;
				mul_b = signed'({3'b000, cfg.out_level});
			end
			OP_PM1: begin
				mul_a = m_q;
				mul_b = signed'({3'b000, one_minus_pm});
			end
			OP_PM2: begin
				mul_a = q_q;
				mul_b = signed'({3'b000, cfg.pres_mix});
			end
			OP_WM1: begin
				mul_a = SH_W'(dry);
				mul_b = signed'({3'b000, one_minus_wm});
			end
			OP_WM2: begin
				mul_a = m_q;
				mul_b = signed'({3'b000, cfg.wet_mix});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mprod     = mul_a * mul_b;
	assign acc_sum   = acc1_q + acc2_q;
	assign acc_shift = acc_sum >>> 16;
	assign lp_new    = LP_W'(acc_shift);

	assign hneg = h_q[H_W-1];
	assign hm   = hneg ? MAG_W'(-h_q) : MAG_W'(h_q);
	assign pmag = p_q[X_W-1] ? MAG_W'(-p_q) : MAG_W'(p_q);
	assign dv   = cmd.pres ? pmag : hm;

	// unsigned multiplier for the phase product and turns conversion
	always_comb begin
		smul_a = '0;
		smul_b = '0;
		unique case (cmd.op)
			OP_SH_PROD: begin
				smul_a = 34'(hm[MAG_W-1:8]);
				smul_b = 30'(dv[MAG_W-1:8]);
			end
			OP_SH_T1: begin
				smul_a = sp_q[SP_W-1:24];
				smul_b = INV_TWO_PI;
			end
			OP_SH_T2: begin
				smul_a = 34'(sp_q[23:0]);
				smul_b = INV_TWO_PI;
			end
			default: begin
				smul_a = '0;
				smul_b = '0;
			end
		endcase
	end

	assign sprod  = smul_a * smul_b;
	assign ph_sum = t1_q + 56'(t2_q);

	// quarter-wave folding of the phase
	assign pos   = phase_q[30] ? (31'h40000000 - {1'b0, phase_q[29:0]})
	                           : {1'b0, phase_q[29:0]};
	assign tidx  = pos[30:FR_W];
	assign tidx1 = (tidx == TI_W'(TAB_N - 1)) ? tidx : tidx + 1'b1;
	assign fr    = pos[FR_W-1:0];

	assign sdiff  = signed'({1'b0, v1_q}) - signed'({1'b0, v0_q});
	assign ip     = sdiff * signed'({1'b0, fr});
	assign interp = signed'({1'b0, v0_q}) + 32'(ip >>> FR_W);

	// divider: two quotient bits per cycle
	assign rem_init = REM_W'(sm_q[SINE_W-1:10]);

	always_comb begin
		div_r  = rem_q;
		div_n  = num_q;
		div_qv = quo_q;
		for (int k = 0; k < DIV_RADIX_BITS; k++) begin
			div_r = {div_r[REM_W-2:0], div_n[DIV_Q_BITS-1]};
			div_n = {div_n[DIV_Q_BITS-2:0], 1'b0};
			if (div_r >= REM_W'(dv)) begin
				div_r  = div_r - REM_W'(dv);
				div_qv = {div_qv[DIV_Q_BITS-2:0], 1'b1};
			end else begin
				div_qv = {div_qv[DIV_Q_BITS-2:0], 1'b0};
			end
		end
	end

	// quotient at or above 2^44 clamps to 2^44
	assign mag       = sat_q ? {1'b1, {DIV_Q_BITS{1'b0}}} : {1'b0, quo_q};
	assign small_arg = (sp_q[SP_W-1:SMALL_BIT] == '0);
	assign dzero     = (dv == '0);
	assign sh_sel    = small_arg ? signed'(SH_W'(hm)) : signed'(SH_W'(mag));
	assign sh_neg    = small_arg ? hneg : (sneg_q ^ hneg);
	assign sh_res    = dzero ? '0 : (sh_neg ? -sh_sel : sh_sel);

	assign y_sh  = y_q >>> DRY_SHIFT;
	assign y_sat = (y_sh > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
	               (y_sh < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(y_sh);

	// filter and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_a_q[0] <= '0;
			lp_a_q[1] <= '0;
			lp_b_q[0] <= '0;
			lp_b_q[1] <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
			fsel_q    <= 1'b1;
		end else begin
			if (cmd.op == OP_LP_SUM) begin
				if (fsel_q) lp_a_q[cmd.ch] <= lp_new;
				else lp_b_q[cmd.ch] <= lp_new;
			end
			if (cmd.op == OP_OUT) prev_q[cmd.ch] <= smp_sel;
			if (cmd.op == OP_EMIT) fsel_q <= ~fsel_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q[0] <= left_sample;
			smp_q[1] <= right_sample;
		end
		unique case (cmd.op)
			OP_GAIN_X: x_q <= X_W'(mprod >>> 16);
			OP_GAIN_P: p_q <= X_W'(mprod >>> 16);
			OP_LP1:    acc1_q <= mprod;
			OP_LP2:    acc2_q <= mprod;
			OP_HP:     h_q <= H_W'(x_q) - H_W'(lp_sel);
			OP_SH_PROD: sp_q <= sprod[SP_W-1:0];
			OP_SH_T1:  t1_q <= sprod[55:0];
			OP_SH_T2:  t2_q <= sprod[53:24];
			OP_SH_PHASE: phase_q <= ph_sum[55:24];
			OP_SH_ROM: begin
				v0_q <= SINE_ROM[tidx];
				v1_q <= SINE_ROM[tidx1];
			end
			OP_SH_INTERP: begin
				sm_q   <= interp[SINE_W-1:0];
				sneg_q <= phase_q[31];
			end
			OP_DIV_INIT: begin
				rem_q <= rem_init;
				num_q <= {sm_q[9:0], 34'b0};
				quo_q <= '0;
				sat_q <= (rem_init >= REM_W'(dv));
			end
			OP_DIV_STEP: begin
				rem_q <= div_r;
				num_q <= div_n;
				quo_q <= div_qv;
			end
			OP_SH_DONE: begin
				if (cmd.pres) q_q <= sh_res;
				else m_q <= sh_res;
			end
			OP_OL_M: if (cfg.out_level != UNITY) m_q <= SH_W'(mprod >>> 16);
			OP_OL_Q: if (cfg.out_level != UNITY) q_q <= SH_W'(mprod >>> 16);
			OP_PM1:  acc1_q <= mprod;
			OP_PM2:  acc2_q <= mprod;
			OP_PM3:  if (cfg.pres_mix != '0) m_q <= SH_W'(acc_shift);
			OP_WM1:  acc1_q <= mprod;
			OP_WM2:  acc2_q <= mprod;
			OP_WM3:  y_q <= (cfg.wet_mix != UNITY) ? SH_W'(acc_shift) : m_q;
			OP_OUT:  stage_q[cmd.ch] <= y_sat;
			OP_EMIT: begin
				left_out  <= stage_q[0];
				right_out <= stage_q[1];
			end
			default: ;
		endcase
	end

endmodule

>>> design/stereo_sine_saturator_core.sv
// Top level of the stereo sine saturator: configuration registers, sequencer and datapath.
//
//  channel  dir  handshake       payload
//  din      in   valid / ready   left_sample, right_sample (signed, SAMPLE_BITS)
//  dout     out  valid / ready   left_out, right_out (signed, SAMPLE_BITS)
//  wr_*     in   wr_en           wr_index (3 bits), wr_data (19 bits)
//
// The time from accepting a frame to a loaded output register covers both channels and the
// load, and is set mostly by the shaper divisions (two per channel, two quotient bits a cycle).
// A new frame is taken only after the sequencer has returned to idle.
// din is ready only while the sequencer is idle; one finished frame waits in the output
// register, and a second frame stalls at its last step until dout takes the first.
// Reset clears the filter states, the sample history and the handshake state at once.
module stereo_sine_saturator_core import ssat_pkg::*; #(
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
	parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	ssat_in_if.sink          din,
	ssat_out_if.source       dout
);

	logic [GAIN_W-1:0] gain_q;
	logic [COEF_W-1:0] hp_q, pm_q, ol_q, wm_q;
	cfg_t              cfg;
	cmd_t              cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			hp_q   <= '0;
			pm_q   <= '0;
			ol_q   <= UNITY;
			wm_q   <= UNITY;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_INPUT_GAIN:     gain_q <= wr_data[GAIN_W-1:0];
				REG_HIGHPASS_COEFF: hp_q   <= wr_data[COEF_W-1:0];
				REG_PRESENCE_MIX:   pm_q   <= wr_data[COEF_W-1:0];
				REG_OUTPUT_LEVEL:   ol_q   <= wr_data[COEF_W-1:0];
				REG_WET_MIX:        wm_q   <= wr_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// fractions above unity act as unity
	always_comb begin
		cfg.gain      = gain_q;
		cfg.hp_coeff  = (hp_q > UNITY) ? UNITY : hp_q;
		cfg.pres_mix  = (pm_q > UNITY) ? UNITY : pm_q;
		cfg.out_level = (ol_q > UNITY) ? UNITY : ol_q;
		cfg.wet_mix   = (wm_q > UNITY) ? UNITY : wm_q;
	end

	ssat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.cmd       (cmd)
	);

	ssat_dp #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.left_sample  (din.left_sample),
		.right_sample (din.right_sample),
		.left_out     (dout.left_out),
		.right_out    (dout.right_out)
	);

endmodule

>>> sim/ssat_checker.sv
// Frame checker: predicts each processed stereo frame and compares it with the block's output.
module ssat_checker import ssat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	ssat_in_if               din,
	ssat_out_if              dout,
	output int               fail_count,
	output int               frames_pending,
	output int               frames_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBITS = 10;
	localparam int TSIZE = (1 << TBITS) + 1;
	localparam longint ONE = 65536;
	localparam longint unsigned INV_2PI = 64'd683565276;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} frame_t;

	longint sin_rom [TSIZE];
	longint drive_gain, hp_c, pres_c, level_c, wet_c;
	longint lp_state [2][2];
	longint prev_dry [2];
	logic   use_first;
	frame_t expected_frames [$];

	function automatic longint clamp1(input longint v);
		return (v > ONE) ? ONE : v;
	endfunction

	function automatic longint rom_entry(input int i);
		longint x, u, acc;
		x = longint'(i) <<< (30 - TBITS);
		u = (x * x) >>> 30;
		acc = -64'sd3864;
		acc = 64'sd172272 + ((acc * u) >>> 30);
		acc = -64'sd5026995 + ((acc * u) >>> 30);
		acc = 64'sd85569306 + ((acc * u) >>> 30);
		acc = -64'sd693598668 + ((acc * u) >>> 30);
		acc = 64'sd1686629713 + ((acc * u) >>> 30);
		acc = (acc * x) >>> 30;
		if (acc < 0) acc = 0;
		if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
		return acc;
	endfunction

	// phase in 2^-32 turns -> Q.30 sine, quarter-wave table with linear interpolation
	function automatic longint sine_q30(input longint unsigned phase);
		longint unsigned quad, r, pos, idx;
		longint fr, v;
		quad = (phase >> 30) & 3;
		r = phase & ((64'd1 << 30) - 1);
		pos = quad[0] ? ((64'd1 << 30) - r) : r;
		idx = pos >> (30 - TBITS);
		fr = longint'(pos & ((64'd1 << (30 - TBITS)) - 1));
		if (idx > TSIZE - 1) idx = TSIZE - 1;
		v = sin_rom[idx];
		if (idx < TSIZE - 1) v = v + (((sin_rom[idx + 1] - v) * fr) >>> (30 - TBITS));
		return (quad >= 2) ? -v : v;
	endfunction

	// sin(a*d)/d, Q.32 in and out
	function automatic longint sine_over(input longint unsigned a, input longint unsigned d);
		longint unsigned prod, t, phase, sm, q1, rem, mag;
		longint s;
		if (d == 0) return 0;
		prod = (a >> 8) * (d >> 8);
		if (prod < (64'd1 << 38)) return longint'(a);
		t = (prod >> 24) * INV_2PI + (((prod & 64'hFFFFFF) * INV_2PI) >> 24);
		phase = (t >> 24) & 64'hFFFFFFFF;
		s = sine_q30(phase);
		sm = (s < 0) ? longint'(-s) : longint'(s);
		q1 = (sm << 30) / d;
		rem = (sm << 30) % d;
		if (q1 >= (64'd1 << 40)) mag = 64'd1 << 44;
		else mag = (q1 << 4) + ((rem << 4) / d);
		return (s < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic signed [23:0] saturate_channel(input int ch,
			input logic signed [23:0] smp);
		longint c, pm, ol, wm, dry, x, p, h, m, q, y, lp;
		longint unsigned hm, pmag;
		int sel;
		c = clamp1(hp_c);
		pm = clamp1(pres_c);
		ol = clamp1(level_c);
		wm = clamp1(wet_c);
		sel = use_first ? 0 : 1;
		dry = longint'(smp) * 512;
		x = (dry * drive_gain) >>> 16;
		p = ((prev_dry[ch] * 512) * drive_gain) >>> 16;
		lp = (lp_state[ch][sel] * (ONE - c) + x * c) >>> 16;
		lp_state[ch][sel] = lp;
		h = x - lp;
		hm = (h < 0) ? -h : h;
		pmag = (p < 0) ? -p : p;
		m = sine_over(hm, hm);
		q = sine_over(hm, pmag);
		if (h < 0) begin
			m = -m;
			q = -q;
		end
		if (ol < ONE) begin
			m = (m * ol) >>> 16;
			q = (q * ol) >>> 16;
		end
		if (pm > 0) m = (m * (ONE - pm) + q * pm) >>> 16;
		y = m;
		if (wm < ONE) y = (dry * (ONE - wm) + m * wm) >>> 16;
		prev_dry[ch] = longint'(smp);
		y = y >>> 9;
		if (y > 8388607) y = 8388607;
		if (y < -8388608) y = -8388608;
		return y[23:0];
	endfunction

	initial begin
		for (int i = 0; i < TSIZE; i++) sin_rom[i] = rom_entry(i);
	end

	assign frames_pending = expected_frames.size();

	always @(posedge clk or negedge arst_n) begin
		frame_t f, e;
		if (!arst_n) begin
			drive_gain = 65536;
			hp_c = 0;
			pres_c = 0;
			level_c = 65536;
			wet_c = 65536;
			lp_state = '{'{0, 0}, '{0, 0}};
			prev_dry = '{0, 0};
			use_first = 1'b1;
			expected_frames.delete();
			fail_count = 0;
			frames_checked = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_INPUT_GAIN:     drive_gain = wr_data;
					REG_HIGHPASS_COEFF: hp_c = wr_data[16:0];
					REG_PRESENCE_MIX:   pres_c = wr_data[16:0];
					REG_OUTPUT_LEVEL:   level_c = wr_data[16:0];
					REG_WET_MIX:        wet_c = wr_data[16:0];
					default: ;
				endcase
			end
			if (din.valid && din.ready) begin
				f.left = saturate_channel(0, din.left_sample);
				f.right = saturate_channel(1, din.right_sample);
				use_first = ~use_first;
				expected_frames.push_back(f);
			end
			if (dout.valid && dout.ready) begin
				if (expected_frames.size() == 0) begin
					fail_count++;
					$display("%0t: output transaction with nothing expected: L=%0d R=%0d",
						$time, dout.left_out, dout.right_out);
				end else begin
					e = expected_frames.pop_front();
					frames_checked++;
					if (dout.left_out !== e.left) begin
						fail_count++;
						$display("%0t: left_out mismatch: expected %0d, actual %0d",
							$time, e.left, dout.left_out);
					end
					if (dout.right_out !== e.right) begin
						fail_count++;
						$display("%0t: right_out mismatch: expected %0d, actual %0d",
							$time, e.right, dout.right_out);
					end
				end
			end
		end
	end
endmodule

>>> sim/stereo_sine_saturator_core_tb.sv
// Top of the saturator testbench: clock, reset, frame stimulus, register phases and verdict.
module stereo_sine_saturator_core_tb;
	import ssat_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	int               fail_count, frames_pending, frames_checked;
	int               cycle_count = 0;
	int               frames_sent = 0;
	int               settings_used = 0;
	logic             no_idle = 1'b0;

	ssat_in_if  din ();
	ssat_out_if dout ();

	stereo_sine_saturator_core u_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .din(din), .dout(dout)
	);

	ssat_checker u_checker (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .din(din), .dout(dout), .fail_count(fail_count),
		.frames_pending(frames_pending), .frames_checked(frames_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		din.valid = 1'b0;
		din.left_sample = '0;
		din.right_sample = '0;
		dout.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d frames outstanding",
				cycle_count, frames_pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// sink side: random stall before each output transaction
	always begin
		int gap;
		@(negedge clk);
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			dout.ready <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		dout.ready <= 1'b1;
		do @(posedge clk); while (!(dout.valid && arst_n));
	end

	// called at a falling edge, returns at a falling edge after the transaction
	task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din.valid <= 1'b1;
		din.left_sample <= l;
		din.right_sample <= r;
		do @(posedge clk); while (!din.ready);
		@(negedge clk);
		frames_sent++;
	endtask

	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// drain outstanding frames, then give the sequencer time to go idle
	task automatic wait_idle();
		din.valid <= 1'b0;
		while (frames_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_settings(input int g, input int c, input int p, input int o,
			input int w);
		wait_idle();
		reg_write(REG_INPUT_GAIN, CFG_W'(g));
		reg_write(REG_HIGHPASS_COEFF, CFG_W'(c));
		reg_write(REG_PRESENCE_MIX, CFG_W'(p));
		reg_write(REG_OUTPUT_LEVEL, CFG_W'(o));
		reg_write(REG_WET_MIX, CFG_W'(w));
		settings_used++;
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 5))
			0:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			1:       return 24'($signed($urandom_range(0, 512)) - 256);
			2:       return 24'($signed($urandom_range(0, 131072)) - 65536);
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic random_frames(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
			send_frame(pick_sample(), pick_sample());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset settings, then presence path active with a filter
		send_frame(24'h000000, 24'h000000);
		send_frame(24'h7FFFFF, 24'h800000);
		send_frame(24'h800000, 24'h7FFFFF);
		send_frame(24'h000001, 24'hFFFFFF);
		send_frame(24'h000000, 24'h000010);
		send_frame(24'h400000, 24'hC00000);
		load_settings(32768, 8192, 32768, 49152, 40000);
		send_frame(24'h000000, 24'h000000);
		send_frame(24'h000004, 24'hFFFFFC);
		send_frame(24'h7FFFFF, 24'h800000);
		send_frame(24'h7FFFFF, 24'h7FFFFF);
		send_frame(24'h000000, 24'h800000);
		send_frame(24'h123456, 24'hEDCBA9);
		send_frame(24'h555555, 24'hAAAAAA);
		load_settings(262144, 65536, 65536, 0, 0);
		send_frame(24'h7FFFFF, 24'h800000);
		send_frame(24'h800000, 24'h7FFFFF);
		send_frame(24'h000001, 24'h000000);
		send_frame(24'h000000, 24'h000001);
		load_settings(0, 0, 65536, 65536, 65536);
		send_frame(24'h7FFFFF, 24'h800000);
		send_frame(24'h3FFFFF, 24'hC00001);
		wait_idle();
		reg_write(3'd5, 19'h7FFFF);
		reg_write(3'd7, 19'h00000);
		send_frame(24'h2AAAAA, 24'hD55556);

		load_settings(65536, 0, 0, 65536, 65536);
		random_frames(80);
		load_settings(262144, 65536, 65536, 0, 0);
		random_frames(70);
		for (int k = 0; k < 6; k++) begin
			load_settings($urandom_range(0, 262144), $urandom_range(0, 65536),
				$urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65536));
			random_frames(70);
		end
		load_settings(131072, 100, 65535, 65535, 1);
		random_frames(60);
		load_settings(0, 65536, 0, 1, 65535);
		random_frames(20);

		wait_idle();
		$display("Sent %0d frames, checked %0d, across %0d register settings",
			frames_sent, frames_checked, settings_used);
		$display("Register extremes, presence blend and dry/wet mix all exercised");
		if (fail_count == 0 && frames_checked == frames_sent) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
